// ===== hw/rtl/sorted_table_binary_search_unit_macros.svh =====
// assertion macros used by the top rtl file
// they expect clk and arst_n in scope
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define STBS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define STBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define STBS_ASSERT_IMPL(label, ante, cons)
`define STBS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/stbs_pkg.sv =====
`default_nettype none
package stbs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int WORD_WIDTH_DEF  = 32;

	localparam int IDX_W   = 10;
	localparam int FIELD_W = 32;
	localparam int CNT_W   = 11;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	localparam logic REG_IDX_ELEMENT_COUNT = 1'b0;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SEARCH = 1'b1
	} opcode_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stbs_ram.sv =====
`default_nettype none
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_table_binary_search_unit.sv =====
// sorted table binary search unit
//
// s_axis carries one request per beat: tuser[0] is the opcode (0 load, 1 search),
// a load stores write_value at write_index, a search looks for search_key among
// the first element_count entries, set through the apb port at address 0.
// a load gives no result; a search gives one m_axis beat with found and position.
// the search is a pipeline of one level per probe, clog2(TABLE_DEPTH+1) levels,
// each level with its own copy of the table; a load walks the same levels and
// writes each copy as it passes, so searches see loads in request order.
// a request enters every cycle while the output is not stalled; a search result
// passes the input register, one register per level and the output register
// before it appears on m_axis.
// reset clears element_count and all valid bits; table contents are not cleared
// and must be loaded before they are searched.
// when m_axis_tready is low with a result waiting, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module sorted_table_binary_search_unit #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
	parameter int WORD_WIDTH  = stbs_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// apb configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [stbs_pkg::APB_AW-1:0]    paddr,
	input  wire logic [stbs_pkg::APB_DW-1:0]    pwdata,
	output logic      [stbs_pkg::APB_DW-1:0]    prdata,
	output logic                                pready,
	// request stream
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// write_index[9:0], write_value[41:10], search_key[73:42], zero[79:74]
	input  wire logic [stbs_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// opcode[0]
	input  wire logic [0:0]                     s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// found[0], position[10:1], zero[15:11]
	output logic [stbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	import stbs_pkg::*;

	localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW     = $clog2(TABLE_DEPTH + 1);
	localparam int LEVELS = CW;

	// configuration
	logic [CNT_W-1:0] element_count_q;
	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_ELEMENT_COUNT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_wr) begin
			element_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_IDX_ELEMENT_COUNT) begin
			prdata = APB_DW'(element_count_q);
		end else begin
			prdata = '0;
		end
	end

	// pipeline
	logic                  advance;
	logic                  out_vld_q;
	logic                  out_fnd_q;
	logic [IDX_W-1:0]      out_pos_q;

	logic                  st_vld_s  [LEVELS+1];
	opcode_t               st_op_s   [LEVELS+1];
	logic [IDX_W-1:0]      st_idx_s  [LEVELS+1];
	logic [WORD_WIDTH-1:0] st_data_s [LEVELS+1];
	logic [CW-1:0]         st_lo_s   [LEVELS+1];
	logic [CW-1:0]         st_hi_s   [LEVELS+1];
	logic                  st_fnd_s  [LEVELS+1];
	logic [AW-1:0]         st_pos_s  [LEVELS+1];
	logic                  st_prb_s  [1:LEVELS];
	logic [AW-1:0]         st_mid_s  [1:LEVELS];

	logic [CW-1:0]         res_lo    [LEVELS+1];
	logic [CW-1:0]         res_hi    [LEVELS+1];
	logic                  res_fnd   [LEVELS+1];
	logic [AW-1:0]         res_pos   [LEVELS+1];

	logic                  act       [LEVELS];
	logic [AW-1:0]         mid       [LEVELS];
	logic                  ram_we    [LEVELS];
	logic                  ram_re    [LEVELS];
	logic [AW-1:0]         ram_addr  [LEVELS];
	logic [WORD_WIDTH-1:0] ram_rdata [LEVELS];

	assign advance       = !out_vld_q || m_axis_tready;
	assign s_axis_tready = advance;

	// input decode
	opcode_t               in_op;
	logic [FIELD_W-1:0]    in_field;
	logic [63:0]           in_ext;
	logic [31:0]           cnt_ext;
	logic [CW-1:0]         hi_init;

	assign in_op    = opcode_t'(s_axis_tuser[0]);
	assign in_field = (in_op == OP_LOAD) ? s_axis_tdata[41:10] : s_axis_tdata[73:42];
	assign in_ext   = {{(64 - FIELD_W){in_field[FIELD_W-1]}}, in_field};
	assign cnt_ext  = 32'(element_count_q);
	assign hi_init  = (cnt_ext > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_s[0] <= 1'b0;
		end else if (advance) begin
			st_vld_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_op_s[0]   <= in_op;
			st_idx_s[0]  <= s_axis_tdata[IDX_W-1:0];
			st_data_s[0] <= in_ext[WORD_WIDTH-1:0];
			st_lo_s[0]   <= '0;
			st_hi_s[0]   <= hi_init;
			st_fnd_s[0]  <= 1'b0;
			st_pos_s[0]  <= '0;
		end
	end

	assign res_lo[0]  = st_lo_s[0];
	assign res_hi[0]  = st_hi_s[0];
	assign res_fnd[0] = st_fnd_s[0];
	assign res_pos[0] = st_pos_s[0];

	for (genvar k = 1; k <= LEVELS; k++) begin : g_resolve
		// fold in the probe issued one level up
		always_comb begin
			res_lo[k]  = st_lo_s[k];
			res_hi[k]  = st_hi_s[k];
			res_fnd[k] = st_fnd_s[k];
			res_pos[k] = st_pos_s[k];
			if (st_prb_s[k]) begin
				if (ram_rdata[k-1] == st_data_s[k]) begin
					res_fnd[k] = 1'b1;
					res_pos[k] = st_mid_s[k];
				end else if ($signed(ram_rdata[k-1]) > $signed(st_data_s[k])) begin
					res_hi[k] = CW'(st_mid_s[k]);
				end else begin
					res_lo[k] = CW'(st_mid_s[k]) + CW'(1);
				end
			end
		end
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_level
		logic [CW-1:0] mid_full;
		logic          idx_ok;

		assign mid_full = res_lo[k] + ((res_hi[k] - res_lo[k]) >> 1);
		assign mid[k]   = mid_full[AW-1:0];
		assign idx_ok   = 32'(st_idx_s[k]) < 32'(TABLE_DEPTH);
		assign act[k]   = st_vld_s[k] && (st_op_s[k] == OP_SEARCH) && !res_fnd[k]
			&& (res_lo[k] < res_hi[k]);

		assign ram_we[k]   = advance && st_vld_s[k] && (st_op_s[k] == OP_LOAD) && idx_ok;
		assign ram_re[k]   = advance && act[k];
		assign ram_addr[k] = (st_op_s[k] == OP_LOAD) ? AW'(st_idx_s[k]) : mid[k];

		stbs_ram #(
			.WIDTH (WORD_WIDTH),
			.DEPTH (TABLE_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[k]),
			.re    (ram_re[k]),
			.addr  (ram_addr[k]),
			.wdata (st_data_s[k]),
			.rdata (ram_rdata[k])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_vld_s[k+1] <= 1'b0;
			end else if (advance) begin
				st_vld_s[k+1] <= st_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				st_op_s[k+1]   <= st_op_s[k];
				st_idx_s[k+1]  <= st_idx_s[k];
				st_data_s[k+1] <= st_data_s[k];
				st_lo_s[k+1]   <= res_lo[k];
				st_hi_s[k+1]   <= res_hi[k];
				st_fnd_s[k+1]  <= res_fnd[k];
				st_pos_s[k+1]  <= res_pos[k];
				st_prb_s[k+1]  <= act[k];
				st_mid_s[k+1]  <= mid[k];
			end
		end
	end

	// output register, loads drop out here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= st_vld_s[LEVELS] && (st_op_s[LEVELS] == OP_SEARCH);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_fnd_q <= res_fnd[LEVELS];
			out_pos_q <= IDX_W'(res_pos[LEVELS]);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W - 1){1'b0}}, out_pos_q, out_fnd_q};

	`include "sorted_table_binary_search_unit_macros.svh"

	// a search that leaves the last level unmatched has an empty range
	`STBS_ASSERT_IMPL(a_search_exhausted, st_vld_s[LEVELS] && (st_op_s[LEVELS] == OP_SEARCH) && !res_fnd[LEVELS], res_lo[LEVELS] >= res_hi[LEVELS])
	`STBS_ASSERT_IMPL(a_miss_pos_zero, out_vld_q && !out_fnd_q, out_pos_q == '0)
	`STBS_ASSERT_NEXT(a_stall_holds, out_vld_q && !m_axis_tready, $stable(st_vld_s[0]) && $stable(st_vld_s[LEVELS]) && $stable(out_pos_q))
	`STBS_ASSERT_IMPL(a_result_from_search, $rose(out_vld_q), $past(st_vld_s[LEVELS]) && ($past(st_op_s[LEVELS]) == OP_SEARCH))

endmodule
`default_nettype wire
